@@ src/cham64_pkg.sv @@
package cham64_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // Direction of a transaction.
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_INV = 1'b1;

  localparam int WORD_W  = 16;
  localparam int BLOCK_W = 64;
  localparam int KEY_W   = 64;
  localparam int RIN_W   = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new transaction
    logic step;   // run one round
    logic emit;   // move the state into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;   // no rounds left in the range
  } sts_t;

  // Rotate a 16-bit word left.
  function automatic logic [WORD_W-1:0] rol16(input logic [WORD_W-1:0] x,
                                               input logic [3:0] r);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << r;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  // Round key idx of the 16-entry schedule, straight from the key words.
  // Keys 0..7 mix with rotations 1 and 8; the others with 1 and 11, placed
  // at ((j + 8) xor 1) for key word j.
  function automatic logic [WORD_W-1:0] round_key(input logic [KEY_W-1:0] kl,
                                                   input logic [KEY_W-1:0] kh,
                                                   input logic [3:0] idx);
    logic [2:0]        w;
    logic [KEY_W-1:0]  src;
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] rk;
    w   = idx[3] ? (idx[2:0] ^ 3'b001) : idx[2:0];
    src = w[2] ? kh : kl;
    k   = WORD_W'(src >> {w[1:0], 4'b0000});
    if (!idx[3]) begin
      rk = k ^ rol16(k, 4'd1) ^ rol16(k, 4'd8);
    end else begin
      rk = k ^ rol16(k, 4'd1) ^ rol16(k, 4'd11);
    end
    return rk;
  endfunction

endpackage

@@ src/cham64_ctrl.sv @@
module cham64_ctrl
  import cham64_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Sequencing: load, one round per cycle, then hand off to the output.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/cham64_dp.sv @@
module cham64_dp
  import cham64_pkg::*;
#(
  parameter int MAX_ROUND = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  logic                 in_kind,
  input  logic [BLOCK_W-1:0]   in_block_in,
  input  logic [RIN_W-1:0]     in_start_round,
  input  logic [RIN_W-1:0]     in_end_round,
  output logic [BLOCK_W-1:0]   out_block_out,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int RND_W = $clog2(MAX_ROUND + 1);
  localparam logic [RND_W-1:0] MAX_R = RND_W'(MAX_ROUND);

  logic [KEY_W-1:0]   key_low_r, key_high_r;
  logic               kind_r;
  logic [RND_W-1:0]   lo_r, hi_r, cur_r, cur_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic [BLOCK_W-1:0] out_block_r;

  logic [RND_W-1:0]   start_sat, end_sat;
  logic [RND_W-1:0]   ridx;
  logic [WORD_W-1:0]  ridx16;
  logic [WORD_W-1:0]  rk;
  logic [WORD_W-1:0]  s0, s1, s2, s3;
  logic [3:0]         rot_a, rot_b, rot_b_inv;
  logic [WORD_W-1:0]  f_sum, f_t;
  logic [WORD_W-1:0]  i_t0, i_sub, i_x;

  // Key registers; an index past the list has no register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Round bounds saturate at the largest round index.
  assign start_sat = (17'(in_start_round) > 17'(MAX_ROUND)) ? MAX_R
                                                            : RND_W'(in_start_round);
  assign end_sat   = (17'(in_end_round) > 17'(MAX_ROUND)) ? MAX_R
                                                          : RND_W'(in_end_round);

  // Forward runs while cur < hi; backward runs round cur-1 while cur > lo.
  assign sts.done = (kind_r == KIND_INV) ? (cur_r <= lo_r) : (cur_r >= hi_r);
  assign ridx     = (kind_r == KIND_INV) ? (cur_r - RND_W'(1)) : cur_r;
  assign ridx16   = WORD_W'(ridx);
  assign rk       = round_key(key_low_r, key_high_r, ridx[3:0]);

  assign s0 = blk_r[15:0];
  assign s1 = blk_r[31:16];
  assign s2 = blk_r[47:32];
  assign s3 = blk_r[63:48];

  // Even rounds rotate by 1 then 8, odd rounds by 8 then 1.
  assign rot_a     = ridx[0] ? 4'd8 : 4'd1;
  assign rot_b     = ridx[0] ? 4'd1 : 4'd8;
  assign rot_b_inv = ridx[0] ? 4'd15 : 4'd8;

  // Forward round: add, rotate, shift the words down.
  assign f_sum = (s0 ^ ridx16) + (rol16(s1, rot_a) ^ rk);
  assign f_t   = rol16(f_sum, rot_b);

  // Inverse round: undo the rotate and the add, shift the words up.
  assign i_t0  = rol16(s3, rot_b_inv);
  assign i_sub = rol16(s0, rot_a) ^ rk;
  assign i_x   = (i_t0 - i_sub) ^ ridx16;

  always_comb begin
    blk_nxt = blk_r;
    cur_nxt = cur_r;
    priority if (cmd.load) begin
      blk_nxt = in_block_in;
      cur_nxt = (in_kind == KIND_INV) ? end_sat : start_sat;
    end else if (cmd.step) begin
      if (kind_r == KIND_INV) begin
        blk_nxt = {s2, s1, s0, i_x};
        cur_nxt = cur_r - RND_W'(1);
      end else begin
        blk_nxt = {f_t, s3, s2, s1};
        cur_nxt = cur_r + RND_W'(1);
      end
    end
  end

  // Working state and the round range of the transaction in flight.
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    cur_r <= cur_nxt;
    if (cmd.load) begin
      kind_r <= in_kind;
      lo_r   <= start_sat;
      hi_r   <= end_sat;
    end
  end

  // Output register frees the core for the next transaction.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_block_r <= blk_r;
    end
  end

  assign out_block_out = out_block_r;

endmodule

@@ src/cham64_round_range_cipher_top.sv @@
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_stall    | in_kind, in_block_in, in_start_round,
//          |                        | in_end_round
// result   | out_valid / out_stall  | out_block_out
// config   | cfg_we                 | cfg_index, cfg_wdata
//
// A transaction runs from acceptance to the next acceptance as a load, one
// round per cycle on the shared round unit, and a move of the state into the
// output register.
// Reset (rst_n low, synchronous) clears the controller and both key registers.
// The output register holds a result under out_stall while the next
// transaction is computed; the core waits at its end until that register frees.
module cham64_round_range_cipher_top
  import cham64_pkg::*;
#(
  parameter int MAX_ROUND = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [BLOCK_W-1:0]   in_block_in,
  input  logic [RIN_W-1:0]     in_start_round,
  input  logic [RIN_W-1:0]     in_end_round,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BLOCK_W-1:0]   out_block_out
);

  cmd_t cmd;
  sts_t sts;

  cham64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cham64_dp #(
    .MAX_ROUND (MAX_ROUND)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_block_in    (in_block_in),
    .in_start_round (in_start_round),
    .in_end_round   (in_end_round),
    .out_block_out  (out_block_out),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

@@ tb/sv/cham64_round_range_cipher_top_test.sv @@
module cham64_round_range_cipher_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cham64_pkg::*;

  localparam int MAX_ROUND    = 255;
  localparam int GAP_MAX      = 13;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES       = 6;
  localparam int REPORT_LIMIT = 10;

  // Keeps the key schedule, computes the expected block of each accepted
  // transaction and compares arriving results in order.
  class cham_result_board;
    logic [WORD_W-1:0]  round_keys[16];
    logic [BLOCK_W-1:0] expected_blocks[$];
    int mismatches;
    int checked;

    function new();
      mismatches = 0;
      checked    = 0;
      set_key('0, '0);
    endfunction

    static function logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                            input int unsigned r);
      logic [WORD_W-1:0] y;
      y = (x << r) | (x >> (WORD_W - r));
      return y;
    endfunction

    // Expand the eight key words into the 16-entry round key schedule.
    function void set_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
      logic [WORD_W-1:0] k;
      for (int w = 0; w < 8; w++) begin
        k = (w < 4) ? lo[16*w +: 16] : hi[16*(w-4) +: 16];
        round_keys[w]           = k ^ rotl(k, 1) ^ rotl(k, 8);
        round_keys[(w + 8) ^ 1] = k ^ rotl(k, 1) ^ rotl(k, 11);
      end
    endfunction

    // Run the rounds of [first, last) forward, or their inverses backward.
    function logic [BLOCK_W-1:0] run_range(input logic kind,
                                           input logic [BLOCK_W-1:0] blk,
                                           input logic [RIN_W-1:0] first,
                                           input logic [RIN_W-1:0] last);
      logic [WORD_W-1:0]  s[4];
      logic [WORD_W-1:0]  sum, sub, t, y;
      logic [BLOCK_W-1:0] res;
      int unsigned lo, hi, a, b, r;
      lo = (first > MAX_ROUND) ? MAX_ROUND : first;
      hi = (last > MAX_ROUND) ? MAX_ROUND : last;
      for (int j = 0; j < 4; j++) s[j] = blk[16*j +: 16];
      if (kind == KIND_FWD) begin
        for (int unsigned i = lo; i < hi; i++) begin
          a    = (i & 1) ? 8 : 1;
          b    = (i & 1) ? 1 : 8;
          sum  = (s[0] ^ i[15:0]) + (rotl(s[1], a) ^ round_keys[i % 16]);
          t    = rotl(sum, b);
          s[0] = s[1];
          s[1] = s[2];
          s[2] = s[3];
          s[3] = t;
        end
      end else begin
        for (int unsigned i = hi; i > lo; i--) begin
          r    = i - 1;
          a    = (r & 1) ? 8 : 1;
          b    = (r & 1) ? 1 : 8;
          y    = s[0];
          t    = rotl(s[3], WORD_W - b);
          sub  = rotl(y, a) ^ round_keys[r % 16];
          s[3] = s[2];
          s[2] = s[1];
          s[1] = y;
          s[0] = (t - sub) ^ r[15:0];
        end
      end
      for (int j = 0; j < 4; j++) res[16*j +: 16] = s[j];
      return res;
    endfunction

    function void note_input(input logic kind, input logic [BLOCK_W-1:0] blk,
                             input logic [RIN_W-1:0] first,
                             input logic [RIN_W-1:0] last);
      expected_blocks.insert(expected_blocks.size(),
                             run_range(kind, blk, first, last));
    endfunction

    function void check_result(input logic [BLOCK_W-1:0] got);
      logic [BLOCK_W-1:0] want;
      checked++;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Result %h arrived with no transaction outstanding", got);
        return;
      end
      want = expected_blocks.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("block_out mismatch on result %0d: expected %h, got %h",
                   checked, want, got);
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = REG_KEY_LOW;
  logic [KEY_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic                 in_kind        = KIND_FWD;
  logic [BLOCK_W-1:0]   in_block_in    = '0;
  logic [RIN_W-1:0]     in_start_round = '0;
  logic [RIN_W-1:0]     in_end_round   = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [BLOCK_W-1:0]   out_block_out;

  cham_result_board board;
  int sent_fwd     = 0;
  int sent_inv     = 0;
  int key_settings = 1;
  int send_run_left = 0;
  bit send_quiet    = 1'b0;

  cham64_round_range_cipher_top #(
    .MAX_ROUND(MAX_ROUND)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_block_in   (in_block_in),
    .in_start_round(in_start_round),
    .in_end_round  (in_end_round),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_out (out_block_out)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one transaction after a random gap and hold it until accepted.
  task automatic send_block(input logic kind, input logic [BLOCK_W-1:0] blk,
                            input logic [RIN_W-1:0] first,
                            input logic [RIN_W-1:0] last);
    int gap;
    if (send_run_left == 0) begin
      send_quiet    = ($urandom_range(0, 3) == 0);
      send_run_left = $urandom_range(10, 60);
    end
    send_run_left--;
    gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_block_in    <= blk;
    in_start_round <= first;
    in_end_round   <= last;
    do @(posedge clk); while (in_stall);
    board.note_input(kind, blk, first, last);
    if (kind == KIND_FWD) sent_fwd++;
    else sent_inv++;
  endtask

  // Stop sending and wait until every outstanding result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both key registers on consecutive edges; the block must be idle.
  task automatic load_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_key(lo, hi);
    key_settings++;
  endtask

  // Result side: stall for a random count of cycles before each result.
  initial begin
    int n;
    int run_left;
    bit quiet;
    run_left = 0;
    quiet    = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (run_left == 0) begin
        quiet    = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      n = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check every accepted result against the oldest expected block.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_block_out);
  end

  // Stimulus: directed cases, then random phases under changing keys.
  initial begin
    logic               kind;
    logic [BLOCK_W-1:0] blk;
    logic [RIN_W-1:0]   first, last;
    int                 cnt, span, pick;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Key registers still hold their reset value of zero.
    send_block(KIND_FWD, '0, 8'd0, 8'd88);
    send_block(KIND_INV, '0, 8'd0, 8'd88);
    send_block(KIND_FWD, '1, 8'd0, 8'd255);
    send_block(KIND_INV, '1, 8'd0, 8'd255);
    send_block(KIND_FWD, 64'h0123_4567_89AB_CDEF, 8'd7, 8'd7);
    send_block(KIND_INV, 64'h0123_4567_89AB_CDEF, 8'd200, 8'd10);
    send_block(KIND_FWD, '1, 8'd255, 8'd255);
    send_block(KIND_FWD, '1, 8'd254, 8'd255);
    send_block(KIND_INV, '1, 8'd254, 8'd255);
    send_block(KIND_FWD, '1, 8'd255, 8'd0);
    send_block(KIND_FWD, 64'hFEDC_BA98_7654_3210, 8'd1, 8'd2);
    send_block(KIND_INV, 64'hFEDC_BA98_7654_3210, 8'd1, 8'd2);

    // All-ones key, then mixed extreme key halves.
    drain_results();
    load_key('1, '1);
    send_block(KIND_FWD, '1, 8'd0, 8'd88);
    send_block(KIND_INV, '1, 8'd0, 8'd88);
    send_block(KIND_FWD, {4{16'hAAAA}}, 8'd0, 8'd16);
    send_block(KIND_INV, {4{16'h5555}}, 8'd0, 8'd16);
    drain_results();
    load_key('0, '1);
    send_block(KIND_FWD, {$urandom, $urandom}, 8'd0, 8'd255);
    send_block(KIND_INV, {$urandom, $urandom}, 8'd0, 8'd255);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == 1) load_key('1, '0);
      else load_key({$urandom, $urandom}, {$urandom, $urandom});
      cnt = 0;
      while (cnt < RANDOM_ITEMS / PHASES) begin
        // Mostly short ranges, some near the standard 88 rounds, some empty.
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          first = RIN_W'($urandom_range(0, 255));
          span  = first + $urandom_range(0, 24);
          last  = (span > 255) ? 8'd255 : span[RIN_W-1:0];
        end else if (pick < 65) begin
          first = RIN_W'($urandom_range(0, 16));
          last  = RIN_W'(first + $urandom_range(60, 88));
        end else if (pick < 80) begin
          first = RIN_W'($urandom_range(0, 255));
          last  = RIN_W'($urandom_range(0, first));
        end else begin
          first = RIN_W'($urandom_range(0, 255));
          last  = RIN_W'($urandom_range(0, 255));
        end
        kind = 1'($urandom_range(0, 1));
        blk  = {$urandom, $urandom};
        send_block(kind, blk, first, last);
        cnt++;
        // Often follow with the opposite direction on the result over the same
        // range, which should give back the original block.
        if ($urandom_range(0, 9) < 4) begin
          send_block((kind == KIND_FWD) ? KIND_INV : KIND_FWD,
                     board.run_range(kind, blk, first, last), first, last);
          cnt++;
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    board.mismatches += board.pending();
    $display("Ran %0d forward and %0d inverse transactions under %0d key settings.",
             sent_fwd, sent_inv, key_settings);
    $display("Checked %0d results, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on run length.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
